// File: rtl/otcd_pkg.sv
// otcd_pkg: shared types and constants for the orientation to cursor delta block
// no dependencies; used by otcd_regs, otcd_delta and orientation_to_cursor_delta_top
package otcd_pkg;

    localparam int HEADING_W = 13;
    localparam int TILT_W    = 13;
    localparam int CFG_W     = 8;
    localparam int DELTA_W   = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CFG_W-1:0] SENSITIVITY_RST = 8'd4;
    localparam logic [CFG_W-1:0] DEADBAND_RST    = 8'd2;

    // register index is byte address bit 2
    typedef enum logic {
        REG_SENSITIVITY = 1'b0,
        REG_DEADBAND    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] sensitivity;
        logic [CFG_W-1:0] deadband;
    } t_cfg;

    typedef struct packed {
        logic [HEADING_W-1:0]     heading;
        logic signed [TILT_W-1:0] tilt;
        logic                     link_up;
    } t_item;

    typedef struct packed {
        logic [HEADING_W-1:0]     heading;
        logic signed [TILT_W-1:0] tilt;
    } t_refs;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic                      move_valid;
        logic                      link_down;
    } t_result;

endpackage

// File: rtl/otcd_regs.sv
// otcd_regs: apb configuration registers (sensitivity, deadband)
// depends on otcd_pkg
module otcd_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [otcd_pkg::APB_AW-1:0]    paddr,
    input  logic [otcd_pkg::APB_DW-1:0]    pwdata,
    output logic [otcd_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output otcd_pkg::t_cfg                 o_cfg
);

    otcd_pkg::t_cfg   r_cfg;
    otcd_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign reg_idx = otcd_pkg::t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensitivity <= otcd_pkg::SENSITIVITY_RST;
            r_cfg.deadband    <= otcd_pkg::DEADBAND_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                otcd_pkg::REG_SENSITIVITY: begin
                    r_cfg.sensitivity <= pwdata[otcd_pkg::CFG_W-1:0];
                end
                otcd_pkg::REG_DEADBAND: begin
                    r_cfg.deadband <= pwdata[otcd_pkg::CFG_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            otcd_pkg::REG_SENSITIVITY: begin
                prdata[otcd_pkg::CFG_W-1:0] = r_cfg.sensitivity;
            end
            otcd_pkg::REG_DEADBAND: begin
                prdata[otcd_pkg::CFG_W-1:0] = r_cfg.deadband;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/otcd_delta.sv
// otcd_delta: one-pass delta datapath, scaling, wrap handling, deadband, saturation
// depends on otcd_pkg
module otcd_delta #(
    parameter int ANGLE_FRAC_BITS = 4
) (
    input  otcd_pkg::t_item   i_item,
    input  otcd_pkg::t_refs   i_refs,
    input  logic              i_primed,
    input  otcd_pkg::t_cfg    i_cfg,
    output otcd_pkg::t_result o_result,
    output otcd_pkg::t_refs   o_next_refs
);

    // angle width holds heading and heading minus a full turn
    localparam int AW = (ANGLE_FRAC_BITS + 10 > 14) ? ANGLE_FRAC_BITS + 10 : 14;
    localparam int PW = AW + otcd_pkg::CFG_W + 1;
    localparam int DW = PW + 1;

    localparam logic signed [AW-1:0] ONE_DEG   = AW'(1) << ANGLE_FRAC_BITS;
    localparam logic signed [AW-1:0] FULL_TURN = AW'(360) << ANGLE_FRAC_BITS;
    localparam logic signed [AW-1:0] NEAR_TURN = AW'(359) << ANGLE_FRAC_BITS;
    localparam logic signed [PW-1:0] TRUNC_BIAS =
        (PW'(1) << ANGLE_FRAC_BITS) - PW'(1);
    localparam logic signed [DW-1:0] SAT_HI = DW'(127);
    localparam logic signed [DW-1:0] SAT_LO = -DW'(128);

    // sens * angle / 2^frac, truncated toward zero
    function automatic logic signed [PW-1:0] scale_angle(
        input logic signed [AW-1:0]              angle,
        input logic signed [otcd_pkg::CFG_W:0]   sens
    );
        logic signed [PW-1:0] prod;
        prod = PW'(sens) * PW'(angle);
        if (prod < 0) begin
            prod = prod + TRUNC_BIAS;
        end
        return prod >>> ANGLE_FRAC_BITS;
    endfunction

    function automatic logic signed [otcd_pkg::DELTA_W-1:0] sat_byte(
        input logic signed [DW-1:0] v
    );
        logic signed [DW-1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[otcd_pkg::DELTA_W-1:0];
    endfunction

    logic [otcd_pkg::HEADING_W-1:0]     ref_h;
    logic signed [otcd_pkg::TILT_W-1:0] ref_t;
    logic signed [AW-1:0]               head_a, refh_a, tilt_a, reft_a;
    logic signed [AW-1:0]               ang_new, ang_ref;
    logic                               wrap_fwd, wrap_bwd;
    logic signed [otcd_pkg::CFG_W:0]    sens_s;
    logic signed [DW-1:0]               db_s, dx, dy;
    logic                               in_db_x, in_db_y;
    logic signed [otcd_pkg::DELTA_W-1:0] dx_sat, dy_sat;

    // first sample primes the references
    assign ref_h = i_primed ? i_refs.heading : i_item.heading;
    assign ref_t = i_primed ? i_refs.tilt    : i_item.tilt;

    assign head_a = signed'({{(AW-otcd_pkg::HEADING_W){1'b0}}, i_item.heading});
    assign refh_a = signed'({{(AW-otcd_pkg::HEADING_W){1'b0}}, ref_h});
    assign tilt_a = {{(AW-otcd_pkg::TILT_W){i_item.tilt[otcd_pkg::TILT_W-1]}}, i_item.tilt};
    assign reft_a = {{(AW-otcd_pkg::TILT_W){ref_t[otcd_pkg::TILT_W-1]}}, ref_t};

    assign wrap_fwd = (head_a > NEAR_TURN) && (refh_a < ONE_DEG);
    assign wrap_bwd = (head_a < ONE_DEG) && (refh_a > NEAR_TURN);

    assign ang_new = wrap_fwd ? head_a - FULL_TURN : head_a;
    assign ang_ref = wrap_bwd ? refh_a - FULL_TURN : refh_a;

    assign sens_s = signed'({1'b0, i_cfg.sensitivity});
    assign db_s   = signed'(DW'(i_cfg.deadband));

    assign dx = DW'(scale_angle(ang_new, sens_s)) - DW'(scale_angle(ang_ref, sens_s));
    assign dy = DW'(scale_angle(reft_a, sens_s)) - DW'(scale_angle(tilt_a, sens_s));

    assign in_db_x = (dx >= -db_s) && (dx <= db_s);
    assign in_db_y = (dy >= -db_s) && (dy <= db_s);

    assign dx_sat = in_db_x ? '0 : sat_byte(dx);
    assign dy_sat = in_db_y ? '0 : sat_byte(dy);

    assign o_next_refs.heading = in_db_x ? ref_h : i_item.heading;
    assign o_next_refs.tilt    = in_db_y ? ref_t : i_item.tilt;

    assign o_result.delta_x    = dx_sat;
    assign o_result.delta_y    = dy_sat;
    assign o_result.move_valid = i_item.link_up && (!in_db_x || !in_db_y);
    assign o_result.link_down  = !i_item.link_up;

endmodule

// File: rtl/orientation_to_cursor_delta_top.sv
// orientation_to_cursor_delta_top: orientation samples in, cursor deltas out
// depends on otcd_pkg, otcd_regs, otcd_delta
//
//  channel   direction  handshake          payload
//  sample    in         i_valid / o_ready  i_heading, i_tilt, i_link_up
//  delta     out        o_valid / i_ready  o_delta_x, o_delta_y, o_move_valid, o_link_down
//  config    in         apb (psel/penable) paddr, pwdata, prdata
//
// one sample per cycle sustained while the delta channel is ready; a sample passes
// through the sample register, then the result register, before delta valid
// the per-axis reference registers and the primed flag are the only feedback: they
// update in the cycle a sample moves from the sample register into the result register
// synchronous active-low reset clears references, primed flag and valids; presets config
// a stalled result holds in the result register while one more sample is taken
module orientation_to_cursor_delta_top #(
    parameter int ANGLE_FRAC_BITS = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [otcd_pkg::HEADING_W-1:0]        i_heading,
    input  logic signed [otcd_pkg::TILT_W-1:0]    i_tilt,
    input  logic                                  i_link_up,
    // delta channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [otcd_pkg::DELTA_W-1:0]   o_delta_x,
    output logic signed [otcd_pkg::DELTA_W-1:0]   o_delta_y,
    output logic                                  o_move_valid,
    output logic                                  o_link_down,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [otcd_pkg::APB_AW-1:0]           paddr,
    input  logic [otcd_pkg::APB_DW-1:0]           pwdata,
    output logic [otcd_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);

    otcd_pkg::t_cfg    cfg;
    otcd_pkg::t_item   r_s1_item;
    logic              r_s1_valid;
    otcd_pkg::t_refs   r_refs;
    otcd_pkg::t_refs   n_refs;
    logic              r_primed;
    otcd_pkg::t_result n_result;
    otcd_pkg::t_result r_out;
    logic              r_out_valid;
    logic              in_xfer;
    logic              s1_adv;

    otcd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    otcd_delta #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_delta (
        .i_item      (r_s1_item),
        .i_refs      (r_refs),
        .i_primed    (r_primed),
        .i_cfg       (cfg),
        .o_result    (n_result),
        .o_next_refs (n_refs)
    );

    // sample register moves on when the result register is free or being drained
    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_xfer = i_valid && o_ready;

    // sample register payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item.heading <= i_heading;
            r_s1_item.tilt    <= i_tilt;
            r_s1_item.link_up <= i_link_up;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_result;
        end
    end

    // control and reference state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_refs      <= '0;
            r_primed    <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_refs      <= n_refs;
                r_primed    <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_delta_x    = r_out.delta_x;
    assign o_delta_y    = r_out.delta_y;
    assign o_move_valid = r_out.move_valid;
    assign o_link_down  = r_out.link_down;

    // once primed, the references stay primed until reset
    a_primed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("primed flag dropped");

    // a move is only flagged with a nonzero delta
    a_move_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_move_valid) |-> (o_delta_x != 0 || o_delta_y != 0))
        else $error("move flagged with zero deltas");

    // move and link-down never together
    a_move_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_move_valid && o_link_down))
        else $error("move flagged while link down");

    // a held sample is neither lost nor overwritten
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("sample register overwritten");

    // references change only when a sample moves into the result register
    a_refs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> $stable(r_refs))
        else $error("reference changed without a sample");

endmodule
